/* design/lavp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lavp_pkg;

  // fixed field widths
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 3;
  localparam int CFG_INDEX_W = 2;

  // quotient bits resolved per fraction divider stage
  localparam int DIV_STEPS = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LESS  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_MORE  = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;

  // label register reset values: x, y, z, w
  localparam logic [CHAR_W-1:0] LABEL_ONE_RESET   = 8'h78;
  localparam logic [CHAR_W-1:0] LABEL_TWO_RESET   = 8'h79;
  localparam logic [CHAR_W-1:0] LABEL_THREE_RESET = 8'h7A;
  localparam logic [CHAR_W-1:0] LABEL_FOUR_RESET  = 8'h77;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_LABEL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LABEL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THIRD_LABEL  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOURTH_LABEL = 2'd3;

  // axis mode codes
  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_LESS     = 2'd1;
  localparam logic [1:0] MODE_MORE     = 2'd2;
  localparam logic [1:0] MODE_RELATIVE = 2'd3;

  // control carried with each parser event
  typedef struct packed {
    logic       commit;
    logic       result;
    logic [1:0] axis;
    logic       negative;
  } event_ctrl_t;

  // result flags and masks; mask and modes already cleared when the text failed
  typedef struct packed {
    logic            ok;
    logic            overflow;
    logic [3:0]      mask;
    logic [3:0][1:0] modes;
  } result_info_t;

  // divisor for a fraction of n digits
  function automatic logic [31:0] pow_ten(input logic [CNT_W-1:0] n);
    logic [31:0] p;
    case (n)
      3'd0:    p = 32'd1;
      3'd1:    p = 32'd10;
      3'd2:    p = 32'd100;
      3'd3:    p = 32'd1000;
      3'd4:    p = 32'd10000;
      3'd5:    p = 32'd100000;
      3'd6:    p = 32'd1000000;
      3'd7:    p = 32'd10000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* design/labeled_axis_value_parser.sv */
// order: the last character's event passes the parser event register, the fraction
//   divider pipeline stages and the output register before its result appears
// throughput: one character per cycle while char_stall is low, the parser keeps its state in one register set
// reset: synchronous active-high rst clears the parse state, restores labels x y z w
//   and empties the pipeline; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module labeled_axis_value_parser #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lavp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lavp_pkg::CHAR_W-1:0]        cfg_data,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  logic [lavp_pkg::CHAR_W-1:0]        char_code,
  input  logic                               is_last,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [lavp_pkg::VALUE_W-1:0] axis_one_value,
  output logic signed [lavp_pkg::VALUE_W-1:0] axis_two_value,
  output logic signed [lavp_pkg::VALUE_W-1:0] axis_three_value,
  output logic signed [lavp_pkg::VALUE_W-1:0] axis_four_value,
  output logic [1:0]                         axis_one_mode,
  output logic [1:0]                         axis_two_mode,
  output logic [1:0]                         axis_three_mode,
  output logic [1:0]                         axis_four_mode,
  output logic [3:0]                         present_mask,
  output logic                               ok,
  output logic                               overflow
);
  import lavp_pkg::*;

  localparam int IW = INT_BITS - 1;
  localparam int DW = $clog2(10**MAX_FRAC_DIGITS);

  // parser to divider
  logic             pe_valid, pe_ready;
  event_ctrl_t      pe_ctrl;
  logic [IW-1:0]    pe_int;
  logic [DW-1:0]    pe_frac;
  logic [CNT_W-1:0] pe_cnt;
  result_info_t     pe_info;

  // divider to value store
  logic                 de_valid, de_ready;
  event_ctrl_t          de_ctrl;
  logic [IW-1:0]        de_int;
  logic [FRAC_BITS-1:0] de_quot;
  result_info_t         de_info;

  // output register
  logic [3:0][VALUE_W-1:0] res_values;
  result_info_t            res_info;

  // labels are plain registers, a write is always taken
  assign cfg_ready = 1'b1;

  lavp_parser #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .is_last    (is_last),
    .ev_valid   (pe_valid),
    .ev_ready   (pe_ready),
    .ev_ctrl    (pe_ctrl),
    .ev_int     (pe_int),
    .ev_frac    (pe_frac),
    .ev_cnt     (pe_cnt),
    .ev_info    (pe_info)
  );

  lavp_frac_div #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_frac_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pe_valid),
    .in_ready  (pe_ready),
    .in_ctrl   (pe_ctrl),
    .in_int    (pe_int),
    .in_frac   (pe_frac),
    .in_cnt    (pe_cnt),
    .in_info   (pe_info),
    .out_valid (de_valid),
    .out_ready (de_ready),
    .out_ctrl  (de_ctrl),
    .out_int   (de_int),
    .out_quot  (de_quot),
    .out_info  (de_info)
  );

  lavp_value_store #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_value_store (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (de_valid),
    .ev_ready   (de_ready),
    .ev_ctrl    (de_ctrl),
    .ev_int     (de_int),
    .ev_quot    (de_quot),
    .ev_info    (de_info),
    .res_valid  (result_valid),
    .res_stall  (result_stall),
    .res_values (res_values),
    .res_info   (res_info)
  );

  // result fields
  assign axis_one_value   = res_values[0];
  assign axis_two_value   = res_values[1];
  assign axis_three_value = res_values[2];
  assign axis_four_value  = res_values[3];
  assign axis_one_mode    = res_info.modes[0];
  assign axis_two_mode    = res_info.modes[1];
  assign axis_three_mode  = res_info.modes[2];
  assign axis_four_mode   = res_info.modes[3];
  assign present_mask     = res_info.mask;
  assign ok               = res_info.ok;
  assign overflow         = res_info.overflow;

endmodule

`default_nettype wire

/* design/lavp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module lavp_parser #(
  parameter int INT_BITS        = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lavp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lavp_pkg::CHAR_W-1:0]         cfg_data,
  input  logic                                char_valid,
  output logic                                char_stall,
  input  logic [lavp_pkg::CHAR_W-1:0]         char_code,
  input  logic                                is_last,
  output logic                                ev_valid,
  input  logic                                ev_ready,
  output lavp_pkg::event_ctrl_t               ev_ctrl,
  output logic [INT_BITS-2:0]                 ev_int,
  output logic [$clog2(10**MAX_FRAC_DIGITS)-1:0] ev_frac,
  output logic [lavp_pkg::CNT_W-1:0]          ev_cnt,
  output lavp_pkg::result_info_t              ev_info
);
  import lavp_pkg::*;

  localparam int IW = INT_BITS - 1;
  localparam int DW = $clog2(10**MAX_FRAC_DIGITS);

  typedef enum logic [2:0] {
    PH_LABEL,
    PH_AFTER_LABEL,
    PH_AFTER_PREFIX,
    PH_AFTER_SIGN,
    PH_NUMBER,
    PH_DONE,
    PH_FAIL
  } phase_t;

  // label registers
  logic [CHAR_W-1:0] label_one, label_two, label_three, label_four;

  // parse state
  phase_t          phase, phase_next;
  logic [1:0]      cur_axis, axis_next;
  logic            negative, neg_next;
  logic            seen_point, point_next;
  logic            seen_digit, digit_next;
  logic [IW-1:0]   int_acc, int_next;
  logic [DW-1:0]   frac_acc, frac_next;
  logic [CNT_W-1:0] frac_cnt, cnt_next;
  logic [3:0][1:0] modes, modes_next;
  logic [3:0]      mask, mask_next;
  logic            saturated, sat_next;

  // character classes
  logic       is_space, is_prefix, is_sign, is_digit, is_point, is_num;
  logic [3:0] dig;
  logic       lbl_hit;
  logic [1:0] lbl_axis;
  logic [1:0] prefix_mode;

  // accumulate candidates
  logic [IW+3:0] int_cand;
  logic          int_over;
  logic [DW+3:0] frac_cand;

  // event build
  logic            accept;
  logic            feed_commit, fin_commit, commit;
  logic            num_step, label_step;
  phase_t          phase_fin;
  logic [3:0]      mask_fin;
  logic            ok;
  event_ctrl_t     ctrl_build;
  result_info_t    info_build;
  logic [IW-1:0]   int_build;
  logic [DW-1:0]   frac_build;
  logic [CNT_W-1:0] cnt_build;

  assign accept     = char_valid && !char_stall;
  assign char_stall = ev_valid && !ev_ready;

  // decode of the incoming character
  assign is_space  = (char_code == CH_SPACE);
  assign is_prefix = (char_code == CH_LESS) || (char_code == CH_MORE) || (char_code == CH_AT);
  assign is_sign   = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_point  = (char_code == CH_POINT);
  assign is_num    = is_digit || is_point;
  assign dig       = char_code[3:0];

  always_comb begin
    if (char_code == CH_LESS) begin
      prefix_mode = MODE_LESS;
    end else if (char_code == CH_MORE) begin
      prefix_mode = MODE_MORE;
    end else begin
      prefix_mode = MODE_RELATIVE;
    end
  end

  // label match, lower axis wins on equal labels
  always_comb begin
    lbl_hit  = 1'b1;
    lbl_axis = 2'd0;
    if (char_code == label_one) begin
      lbl_axis = 2'd0;
    end else if (char_code == label_two) begin
      lbl_axis = 2'd1;
    end else if (char_code == label_three) begin
      lbl_axis = 2'd2;
    end else if (char_code == label_four) begin
      lbl_axis = 2'd3;
    end else begin
      lbl_hit = 1'b0;
    end
  end

  // times ten plus digit, integer part saturates at all ones
  assign int_cand  = ((IW+4)'(int_acc) << 3) + ((IW+4)'(int_acc) << 1) + (IW+4)'(dig);
  assign int_over  = (int_cand > {4'b0000, {IW{1'b1}}});
  assign frac_cand = ((DW+4)'(frac_acc) << 3) + ((DW+4)'(frac_acc) << 1) + (DW+4)'(dig);

  // next state for one character
  always_comb begin
    phase_next  = phase;
    axis_next   = cur_axis;
    neg_next    = negative;
    point_next  = seen_point;
    digit_next  = seen_digit;
    int_next    = int_acc;
    frac_next   = frac_acc;
    cnt_next    = frac_cnt;
    modes_next  = modes;
    mask_next   = mask;
    sat_next    = saturated;
    feed_commit = 1'b0;
    num_step    = 1'b0;
    label_step  = 1'b0;

    case (phase)
      PH_LABEL: begin
        label_step = 1'b1;
      end
      PH_AFTER_LABEL: begin
        if (!is_space) begin
          if (is_prefix) begin
            modes_next[cur_axis] = prefix_mode;
            phase_next = PH_AFTER_PREFIX;
          end else if (is_sign) begin
            neg_next   = (char_code == CH_MINUS);
            phase_next = PH_AFTER_SIGN;
          end else if (is_num) begin
            num_step = 1'b1;
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
      PH_AFTER_PREFIX: begin
        if (!is_space) begin
          if (is_sign) begin
            neg_next   = (char_code == CH_MINUS);
            phase_next = PH_AFTER_SIGN;
          end else if (is_num) begin
            num_step = 1'b1;
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
      PH_AFTER_SIGN: begin
        if (!is_space) begin
          if (is_num) begin
            num_step = 1'b1;
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
      PH_NUMBER: begin
        if (is_num) begin
          num_step = 1'b1;
        end else if (!seen_digit) begin
          phase_next = PH_FAIL;
        end else begin
          // number ends here, the same character may start the next axis
          feed_commit = 1'b1;
          mask_next   = mask | (4'b0001 << cur_axis);
          neg_next    = 1'b0;
          point_next  = 1'b0;
          digit_next  = 1'b0;
          int_next    = '0;
          frac_next   = '0;
          cnt_next    = '0;
          if (mask_next == 4'hF) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_LABEL;
            label_step = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // digit or point of a number
    if (num_step) begin
      phase_next = PH_NUMBER;
      if (is_point) begin
        if (seen_point) begin
          phase_next = PH_FAIL;
        end
        point_next = 1'b1;
      end else begin
        digit_next = 1'b1;
        if (seen_point) begin
          if (frac_cnt < CNT_W'(MAX_FRAC_DIGITS)) begin
            frac_next = frac_cand[DW-1:0];
            cnt_next  = frac_cnt + 1'b1;
          end
        end else if (int_over) begin
          int_next = {IW{1'b1}};
          sat_next = 1'b1;
        end else begin
          int_next = int_cand[IW-1:0];
        end
      end
    end

    // label expected
    if (label_step && !is_space) begin
      if (lbl_hit) begin
        axis_next  = lbl_axis;
        phase_next = PH_AFTER_LABEL;
      end else begin
        phase_next = PH_FAIL;
      end
    end
  end

  // end of text: close an open number and judge the text
  always_comb begin
    fin_commit = 1'b0;
    phase_fin  = phase_next;
    mask_fin   = mask_next;
    if (phase_next == PH_NUMBER) begin
      if (digit_next) begin
        fin_commit = 1'b1;
        mask_fin   = mask_next | (4'b0001 << axis_next);
      end else begin
        phase_fin = PH_FAIL;
      end
    end
    ok = !((phase_fin == PH_FAIL) || (phase_fin == PH_AFTER_LABEL) ||
           (phase_fin == PH_AFTER_PREFIX) || (phase_fin == PH_AFTER_SIGN)) &&
         (mask_fin != 4'd0);
  end

  // event payload, at most one commit per character
  always_comb begin
    commit = feed_commit || (is_last && fin_commit);
    if (feed_commit) begin
      ctrl_build.axis     = cur_axis;
      ctrl_build.negative = negative;
      int_build           = int_acc;
      frac_build          = frac_acc;
      cnt_build           = frac_cnt;
    end else begin
      ctrl_build.axis     = axis_next;
      ctrl_build.negative = neg_next;
      int_build           = int_next;
      frac_build          = frac_next;
      cnt_build           = cnt_next;
    end
    ctrl_build.commit   = commit;
    ctrl_build.result   = is_last;
    info_build.ok       = ok;
    info_build.overflow = sat_next;
    info_build.mask     = ok ? mask_fin : 4'd0;
    info_build.modes    = ok ? modes_next : '0;
  end

  // state, labels and event register
  always_ff @(posedge clk) begin
    if (rst) begin
      label_one   <= LABEL_ONE_RESET;
      label_two   <= LABEL_TWO_RESET;
      label_three <= LABEL_THREE_RESET;
      label_four  <= LABEL_FOUR_RESET;
      phase       <= PH_LABEL;
      cur_axis    <= 2'd0;
      negative    <= 1'b0;
      seen_point  <= 1'b0;
      seen_digit  <= 1'b0;
      int_acc     <= '0;
      frac_acc    <= '0;
      frac_cnt    <= '0;
      modes       <= '0;
      mask        <= 4'd0;
      saturated   <= 1'b0;
      ev_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIRST_LABEL:  label_one   <= cfg_data;
          CFG_SECOND_LABEL: label_two   <= cfg_data;
          CFG_THIRD_LABEL:  label_three <= cfg_data;
          CFG_FOURTH_LABEL: label_four  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (is_last) begin
          phase      <= PH_LABEL;
          cur_axis   <= 2'd0;
          negative   <= 1'b0;
          seen_point <= 1'b0;
          seen_digit <= 1'b0;
          int_acc    <= '0;
          frac_acc   <= '0;
          frac_cnt   <= '0;
          modes      <= '0;
          mask       <= 4'd0;
          saturated  <= 1'b0;
        end else begin
          phase      <= phase_next;
          cur_axis   <= axis_next;
          negative   <= neg_next;
          seen_point <= point_next;
          seen_digit <= digit_next;
          int_acc    <= int_next;
          frac_acc   <= frac_next;
          frac_cnt   <= cnt_next;
          modes      <= modes_next;
          mask       <= mask_next;
          saturated  <= sat_next;
        end
        ev_valid <= commit || is_last;
        ev_ctrl  <= ctrl_build;
        ev_int   <= int_build;
        ev_frac  <= frac_build;
        ev_cnt   <= cnt_build;
        ev_info  <= info_build;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/lavp_frac_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module lavp_frac_div #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  lavp_pkg::event_ctrl_t                  in_ctrl,
  input  logic [INT_BITS-2:0]                    in_int,
  input  logic [$clog2(10**MAX_FRAC_DIGITS)-1:0] in_frac,
  input  logic [lavp_pkg::CNT_W-1:0]             in_cnt,
  input  lavp_pkg::result_info_t                 in_info,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lavp_pkg::event_ctrl_t                  out_ctrl,
  output logic [INT_BITS-2:0]                    out_int,
  output logic [FRAC_BITS-1:0]                   out_quot,
  output lavp_pkg::result_info_t                 out_info
);
  import lavp_pkg::*;

  localparam int IW = INT_BITS - 1;
  localparam int DW = $clog2(10**MAX_FRAC_DIGITS);
  localparam int NS = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // stage registers seen by the next stage
  logic             st_valid [NS];
  event_ctrl_t      st_ctrl  [NS];
  logic [IW-1:0]    st_int   [NS];
  logic [DW-1:0]    st_rem   [NS];
  logic [FRAC_BITS-1:0] st_quot [NS];
  logic [CNT_W-1:0] st_cnt   [NS];
  result_info_t     st_info  [NS];
  logic             ready    [NS+1];

  assign ready[NS] = out_ready;
  assign in_ready  = ready[0];

  // restoring long division of digits * 2^FRAC_BITS by 10^count,
  // remainder stays below the divisor since the digits are fewer than count + 1
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                 valid_src;
    event_ctrl_t          ctrl_src;
    logic [IW-1:0]        int_src;
    logic [DW-1:0]        rem_src;
    logic [FRAC_BITS-1:0] quot_src;
    logic [CNT_W-1:0]     cnt_src;
    result_info_t         info_src;
    logic [DW-1:0]        rem_calc;
    logic [FRAC_BITS-1:0] quot_calc;

    logic                 valid_q;
    event_ctrl_t          ctrl_q;
    logic [IW-1:0]        int_q;
    logic [DW-1:0]        rem_q;
    logic [FRAC_BITS-1:0] quot_q;
    logic [CNT_W-1:0]     cnt_q;
    result_info_t         info_q;

    if (s == 0) begin : g_first
      assign valid_src = in_valid;
      assign ctrl_src  = in_ctrl;
      assign int_src   = in_int;
      assign rem_src   = in_frac;
      assign quot_src  = '0;
      assign cnt_src   = in_cnt;
      assign info_src  = in_info;
    end else begin : g_later
      assign valid_src = st_valid[s-1];
      assign ctrl_src  = st_ctrl[s-1];
      assign int_src   = st_int[s-1];
      assign rem_src   = st_rem[s-1];
      assign quot_src  = st_quot[s-1];
      assign cnt_src   = st_cnt[s-1];
      assign info_src  = st_info[s-1];
    end

    // a few quotient bits per stage
    always_comb begin
      logic [31:0]          pw;
      logic [DW-1:0]        dv;
      logic [DW:0]          r2;
      logic [DW-1:0]        r;
      logic [FRAC_BITS-1:0] q;
      pw = pow_ten(cnt_src);
      dv = pw[DW-1:0];
      r  = rem_src;
      q  = quot_src;
      r2 = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < FRAC_BITS) begin
          r2 = {r, 1'b0};
          if (r2 >= {1'b0, dv}) begin
            r2 = r2 - {1'b0, dv};
            q  = {q[FRAC_BITS-2:0], 1'b1};
          end else begin
            q  = {q[FRAC_BITS-2:0], 1'b0};
          end
          r = r2[DW-1:0];
        end
      end
      rem_calc  = r;
      quot_calc = q;
    end

    assign ready[s] = !valid_q || ready[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q <= 1'b0;
      end else if (ready[s]) begin
        valid_q <= valid_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[s]) begin
        ctrl_q <= ctrl_src;
        int_q  <= int_src;
        rem_q  <= rem_calc;
        quot_q <= quot_calc;
        cnt_q  <= cnt_src;
        info_q <= info_src;
      end
    end

    assign st_valid[s] = valid_q;
    assign st_ctrl[s]  = ctrl_q;
    assign st_int[s]   = int_q;
    assign st_rem[s]   = rem_q;
    assign st_quot[s]  = quot_q;
    assign st_cnt[s]   = cnt_q;
    assign st_info[s]  = info_q;
  end

  assign out_valid = st_valid[NS-1];
  assign out_ctrl  = st_ctrl[NS-1];
  assign out_int   = st_int[NS-1];
  assign out_quot  = st_quot[NS-1];
  assign out_info  = st_info[NS-1];

endmodule

`default_nettype wire

/* design/lavp_value_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module lavp_value_store #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  ev_valid,
  output logic                                  ev_ready,
  input  lavp_pkg::event_ctrl_t                 ev_ctrl,
  input  logic [INT_BITS-2:0]                   ev_int,
  input  logic [FRAC_BITS-1:0]                  ev_quot,
  input  lavp_pkg::result_info_t                ev_info,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [3:0][lavp_pkg::VALUE_W-1:0]     res_values,
  output lavp_pkg::result_info_t                res_info
);
  import lavp_pkg::*;

  localparam int IW = INT_BITS - 1;

  logic [3:0][VALUE_W-1:0] vals;
  logic [IW+FRAC_BITS-1:0] mag;
  logic [VALUE_W-1:0]      mag_v;
  logic [VALUE_W-1:0]      value;
  logic [3:0][VALUE_W-1:0] values_next;
  logic                    take;

  // integer and fraction bits side by side, then the sign
  assign mag   = {ev_int, ev_quot};
  assign mag_v = VALUE_W'(mag);
  assign value = ev_ctrl.negative ? (~mag_v + 1'b1) : mag_v;

  // commits always go in, a result needs the output register
  assign ev_ready = !ev_ctrl.result || !res_valid || !res_stall;
  assign take     = ev_valid && ev_ready;

  // axes absent from the mask read as zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!ev_info.mask[i]) begin
        values_next[i] = '0;
      end else if (ev_ctrl.commit && (ev_ctrl.axis == 2'(i))) begin
        values_next[i] = value;
      end else begin
        values_next[i] = vals[i];
      end
    end
  end

  // stored axis values
  always_ff @(posedge clk) begin
    if (take && ev_ctrl.commit) begin
      vals[ev_ctrl.axis] <= value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && ev_ctrl.result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev_ctrl.result) begin
      res_values <= values_next;
      res_info   <= ev_info;
    end
  end

endmodule

`default_nettype wire

/* design/lavp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lavp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [lavp_pkg::VALUE_W-1:0] axis_one_value,
  input logic signed [lavp_pkg::VALUE_W-1:0] axis_two_value,
  input logic signed [lavp_pkg::VALUE_W-1:0] axis_three_value,
  input logic signed [lavp_pkg::VALUE_W-1:0] axis_four_value,
  input logic [1:0]                         axis_one_mode,
  input logic [1:0]                         axis_two_mode,
  input logic [1:0]                         axis_three_mode,
  input logic [1:0]                         axis_four_mode,
  input logic [3:0]                         present_mask,
  input logic                               ok,
  input logic                               overflow
);

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(present_mask) &&
      $stable(ok) && $stable(overflow) && $stable(axis_one_value) &&
      $stable(axis_two_value) && $stable(axis_three_value) && $stable(axis_four_value))
    else $error("result changed while stalled");

  // a good text always names an axis
  a_ok_has_axis: assert property (@(posedge clk) disable iff (rst)
    result_valid && ok |-> present_mask != 4'd0)
    else $error("ok result without any axis");

  // a failed text reports nothing but overflow
  a_fail_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> present_mask == 4'd0 &&
      axis_one_value == 0 && axis_two_value == 0 &&
      axis_three_value == 0 && axis_four_value == 0 &&
      axis_one_mode == 2'd0 && axis_two_mode == 2'd0 &&
      axis_three_mode == 2'd0 && axis_four_mode == 2'd0)
    else $error("failed result carries axis data");

  // an axis without a value has zero value and plain mode
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (present_mask[0] || (axis_one_value == 0 && axis_one_mode == 2'd0)) &&
      (present_mask[1] || (axis_two_value == 0 && axis_two_mode == 2'd0)) &&
      (present_mask[2] || (axis_three_value == 0 && axis_three_mode == 2'd0)) &&
      (present_mask[3] || (axis_four_value == 0 && axis_four_mode == 2'd0)))
    else $error("absent axis carries data");

endmodule

bind labeled_axis_value_parser lavp_checker u_lavp_checker (.*);

`default_nettype wire
